>>> rtl/gwo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gwo_pkg: shared types and constants for the gyro/wheel odometry unit
// Field widths, microcode control word layout, and the fixed-point sine table.
// ----------------------------------------------------------------------------
package gwo_pkg;

  // Item field widths
  localparam int ENC_W   = 32;
  localparam int GYRO_W  = 16;
  localparam int SPEED_W = 12;
  localparam int POS_W   = 64;
  localparam int HEAD_W  = 9;
  localparam int LIN_W   = 37;
  localparam int ANG_W   = 43;

  // Configuration port
  localparam int WHEEL_W    = 16;
  localparam int TURN_W     = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [WHEEL_W-1:0]       WHEEL_RST  = WHEEL_W'(8785);
  localparam logic [TURN_W-1:0]        TURN_RST   = TURN_W'(73206);
  localparam logic signed [GYRO_W-1:0] OFFSET_RST = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WHEEL_SCALE = 2'd0,
    CFG_TURN_SCALE  = 2'd1,
    CFG_GYRO_OFFSET = 2'd2
  } cfg_idx_t;

  // Trig format
  localparam int TRIG_FRAC  = 15;
  localparam int TAB_W      = TRIG_FRAC + 1;   // unsigned table entry, holds 1.0
  localparam int TRIG_W     = TRIG_FRAC + 2;   // signed sine / cosine
  localparam int TRIG_RND   = 30 - TRIG_FRAC;  // series is in 2^-30 units
  localparam int TRIG_SHIFT = TRIG_FRAC + 1;   // position step divides by 2^(frac+1)
  localparam int TAB_IDX_W  = 7;               // 0..90 degrees
  localparam int TAB_DEPTH  = 91;

  // Angle constants
  localparam int DEG_QTR  = 90;
  localparam int DEG_HALF = 180;
  localparam int DEG_FULL = 360;
  localparam int ABS_W    = 8;                 // |heading| <= 180

  // Heading reduction: u = offset - gyro + bias, always positive, then u mod 360
  localparam int HU_W     = 18;
  localparam int H_BIAS   = 364 * DEG_FULL;
  localparam int RECIP_SH = 22;
  localparam int RECIP    = ((1 << RECIP_SH) + DEG_FULL - 1) / DEG_FULL;
  localparam int QUOT_W   = 10;

  // Position step: m = (dl + dr) * wheel_scale, split into high and low halves
  localparam int SUM_W    = ENC_W + 1;
  localparam int M_W      = SUM_W + WHEEL_W + 1;
  localparam int M_LO_W   = 25;
  localparam int HI_SHIFT = M_LO_W - TRIG_SHIFT;
  localparam int VSP_W    = SPEED_W + 1;

  // Shared multiplier
  localparam int MUL_A_W = SUM_W + 1;
  localparam int MUL_B_W = (TRIG_W > TURN_W + 1) ? TRIG_W : TURN_W + 1;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Microcode
  localparam int UPC_W = 4;

  typedef enum logic [2:0] {
    A_U, A_QUOT, A_SUM, A_M_LO, A_M_HI, A_VSUM, A_VDIFF
  } a_sel_t;

  typedef enum logic [2:0] {
    B_RECIP, B_DEG360, B_WHEEL, B_COS, B_SIN, B_TURN
  } b_sel_t;

  typedef enum logic [3:0] {
    W_NONE, W_HEADING, W_TRIG, W_LIN, W_X_LO, W_X_HI, W_Y_LO, W_Y_HI, W_RESULT
  } wr_op_t;

  typedef enum logic [1:0] {
    JC_NEXT, JC_IF_INPUT, JC_IF_OUT_FREE
  } jump_cond_t;

  typedef struct packed {
    a_sel_t a_sel;
    b_sel_t b_sel;
    logic   mul_en;
    wr_op_t wr_op;
    logic   take_in;
  } dp_ctrl_t;

  typedef struct packed {
    dp_ctrl_t         dp;
    jump_cond_t       jc;
    logic [UPC_W-1:0] target;
  } ucode_word_t;

  typedef struct packed {
    logic in_fire;
    logic out_free;
  } dp_stat_t;

  // Sine table, built at elaboration from a Taylor series in 2^-30 units
  localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
  localparam logic [63:0] DEG_Q60 = PI_Q60 / 64'd180;
  localparam logic [63:0] HALF_Q30 = 64'h0000_0000_2000_0000;

  typedef logic [TAB_DEPTH-1:0][TAB_W-1:0] sin_tab_t;

  // term / ((2n)(2n+1))
  function automatic logic [63:0] series_div(logic [63:0] v, int n);
    logic [63:0] r;
    case (n)
      1:       r = v / 64'd6;
      2:       r = v / 64'd20;
      3:       r = v / 64'd42;
      4:       r = v / 64'd72;
      5:       r = v / 64'd110;
      6:       r = v / 64'd156;
      7:       r = v / 64'd210;
      8:       r = v / 64'd272;
      9:       r = v / 64'd342;
      10:      r = v / 64'd420;
      default: r = v;
    endcase
    return r;
  endfunction

  function automatic sin_tab_t build_sin_tab();
    sin_tab_t           tab;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    tab = '0;
    for (int d = 0; d < TAB_DEPTH; d++) begin
      x    = 64'(d) * DEG_Q60;
      x    = (x + HALF_Q30) >> 30;
      x2   = (x * x + HALF_Q30) >> 30;
      term = x;
      sum  = $signed(x);
      for (int n = 1; n <= 10; n++) begin
        term = series_div((term * x2) >> 30, n);
        if ((n & 1) == 1) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = '0;
      end
      tab[d] = TAB_W'(($unsigned(sum) + (64'd1 << (TRIG_RND - 1))) >> TRIG_RND);
    end
    return tab;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin_tab();

endpackage
`default_nettype wire

>>> rtl/gwo_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gwo_if: item channels of the odometry unit
// Sample input, odometry result and configuration write channels.
// ----------------------------------------------------------------------------

// Sample channel
interface gwo_in_if import gwo_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [ENC_W-1:0]    right_position;
  logic signed [ENC_W-1:0]    left_position;
  logic signed [GYRO_W-1:0]   gyro_angle;
  logic signed [SPEED_W-1:0]  left_speed;
  logic signed [SPEED_W-1:0]  right_speed;

  modport source (
    output valid, right_position, left_position, gyro_angle, left_speed, right_speed,
    input  ready
  );
  modport sink (
    input  valid, right_position, left_position, gyro_angle, left_speed, right_speed,
    output ready
  );
endinterface

// Result channel
interface gwo_out_if import gwo_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [POS_W-1:0]   pos_x;
  logic signed [POS_W-1:0]   pos_y;
  logic signed [HEAD_W-1:0]  heading;
  logic signed [LIN_W-1:0]   lin_velocity;
  logic signed [ANG_W-1:0]   ang_velocity;

  modport source (
    output valid, pos_x, pos_y, heading, lin_velocity, ang_velocity,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, heading, lin_velocity, ang_velocity,
    output ready
  );
endinterface

// Configuration write channel
interface gwo_cfg_if import gwo_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/gwo_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gwo_sequencer: microprogram counter and control store
// Steps through one control word per cycle; waits on input and result space.
// ----------------------------------------------------------------------------
module gwo_sequencer import gwo_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire dp_stat_t stat,
  output dp_ctrl_t      ctrl
);

  // Step addresses
  localparam logic [UPC_W-1:0] UA_WAIT   = 4'd0;
  localparam logic [UPC_W-1:0] UA_QUOT   = 4'd1;
  localparam logic [UPC_W-1:0] UA_REM    = 4'd2;
  localparam logic [UPC_W-1:0] UA_FOLD   = 4'd3;
  localparam logic [UPC_W-1:0] UA_TRIG   = 4'd4;
  localparam logic [UPC_W-1:0] UA_LIN    = 4'd5;
  localparam logic [UPC_W-1:0] UA_XLO    = 4'd6;
  localparam logic [UPC_W-1:0] UA_XHI    = 4'd7;
  localparam logic [UPC_W-1:0] UA_YLO    = 4'd8;
  localparam logic [UPC_W-1:0] UA_YHI    = 4'd9;
  localparam logic [UPC_W-1:0] UA_RESULT = 4'd10;

  logic [UPC_W-1:0] upc_r;
  logic [UPC_W-1:0] upc_nxt;
  ucode_word_t      cw;

  function automatic ucode_word_t uw(a_sel_t a, b_sel_t b, logic me, wr_op_t w,
                                     logic ti, jump_cond_t j, logic [UPC_W-1:0] t);
    ucode_word_t r;
    r.dp.a_sel   = a;
    r.dp.b_sel   = b;
    r.dp.mul_en  = me;
    r.dp.wr_op   = w;
    r.dp.take_in = ti;
    r.jc         = j;
    r.target     = t;
    return r;
  endfunction

  // Control store: multiplier operands issued this step; each step consumes the product registered by its predecessor
  always_comb begin
    case (upc_r)
      UA_WAIT:   cw = uw(A_U,     B_RECIP,  1'b0, W_NONE,    1'b1, JC_IF_INPUT, UA_QUOT);
      UA_QUOT:   cw = uw(A_U,     B_RECIP,  1'b1, W_NONE,    1'b0, JC_NEXT,     UA_WAIT);
      UA_REM:    cw = uw(A_QUOT,  B_DEG360, 1'b1, W_NONE,    1'b0, JC_NEXT,     UA_WAIT);
      UA_FOLD:   cw = uw(A_SUM,   B_WHEEL,  1'b1, W_HEADING, 1'b0, JC_NEXT,     UA_WAIT);
      UA_TRIG:   cw = uw(A_VSUM,  B_WHEEL,  1'b1, W_TRIG,    1'b0, JC_NEXT,     UA_WAIT);
      UA_LIN:    cw = uw(A_M_LO,  B_COS,    1'b1, W_LIN,     1'b0, JC_NEXT,     UA_WAIT);
      UA_XLO:    cw = uw(A_M_HI,  B_COS,    1'b1, W_X_LO,    1'b0, JC_NEXT,     UA_WAIT);
      UA_XHI:    cw = uw(A_M_LO,  B_SIN,    1'b1, W_X_HI,    1'b0, JC_NEXT,     UA_WAIT);
      UA_YLO:    cw = uw(A_M_HI,  B_SIN,    1'b1, W_Y_LO,    1'b0, JC_NEXT,     UA_WAIT);
      UA_YHI:    cw = uw(A_VDIFF, B_TURN,   1'b1, W_Y_HI,    1'b0, JC_NEXT,     UA_WAIT);
      UA_RESULT: cw = uw(A_U,     B_RECIP,  1'b0, W_RESULT,  1'b0, JC_IF_OUT_FREE, UA_WAIT);
      default:   cw = uw(A_U,     B_RECIP,  1'b0, W_NONE,    1'b0, JC_IF_OUT_FREE, UA_WAIT);
    endcase
  end

  assign ctrl = cw.dp;

  // Next address: fall through, or jump once the awaited handshake is possible
  always_comb begin
    case (cw.jc)
      JC_NEXT:        upc_nxt = upc_r + UPC_W'(1);
      JC_IF_INPUT:    upc_nxt = stat.in_fire  ? cw.target : upc_r;
      JC_IF_OUT_FREE: upc_nxt = stat.out_free ? cw.target : upc_r;
      default:        upc_nxt = UA_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= UA_WAIT;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/gwo_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gwo_datapath: registers, shared multiplier and accumulators
// Captures a sample, runs the steps the sequencer selects, holds the result.
// ----------------------------------------------------------------------------
module gwo_datapath import gwo_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire dp_ctrl_t ctrl,
  output dp_stat_t      stat,
  gwo_cfg_if.sink       cfg_ch,
  gwo_in_if.sink        in_ch,
  gwo_out_if.source     out_ch
);

  // Configuration
  logic [WHEEL_W-1:0]        wheel_scale_r;
  logic [TURN_W-1:0]         turn_scale_r;
  logic signed [GYRO_W-1:0]  gyro_offset_r;

  // State across items
  logic [ENC_W-1:0]          prev_right_r;
  logic [ENC_W-1:0]          prev_left_r;
  logic signed [POS_W-1:0]   acc_x_r;
  logic signed [POS_W-1:0]   acc_y_r;

  // Per-item working registers
  logic signed [SUM_W-1:0]   sum_r;
  logic [HU_W-1:0]           hu_r;
  logic signed [VSP_W-1:0]   vsum_r;
  logic signed [VSP_W-1:0]   vdiff_r;
  logic signed [MUL_P_W-1:0] prod_r;
  logic signed [HEAD_W-1:0]  heading_r;
  logic signed [M_W-1:0]     m_r;
  logic signed [TRIG_W-1:0]  sin_r;
  logic signed [TRIG_W-1:0]  cos_r;
  logic signed [LIN_W-1:0]   lin_r;

  // Result register
  logic                      out_valid_r;
  logic signed [POS_W-1:0]   out_x_r;
  logic signed [POS_W-1:0]   out_y_r;
  logic signed [HEAD_W-1:0]  out_head_r;
  logic signed [LIN_W-1:0]   out_lin_r;
  logic signed [ANG_W-1:0]   out_ang_r;

  logic                      in_fire;
  logic                      out_free;
  logic                      result_wr;

  // Handshakes
  assign in_ch.ready   = ctrl.take_in;
  assign in_fire       = in_ch.valid && ctrl.take_in;
  assign out_free      = !out_valid_r || out_ch.ready;
  assign result_wr     = (ctrl.wr_op == W_RESULT) && out_free;
  assign stat.in_fire  = in_fire;
  assign stat.out_free = out_free;
  assign cfg_ch.ready  = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wheel_scale_r <= WHEEL_RST;
      turn_scale_r  <= TURN_RST;
      gyro_offset_r <= OFFSET_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_idx_t'(cfg_ch.index))
        CFG_WHEEL_SCALE: wheel_scale_r <= cfg_ch.data[WHEEL_W-1:0];
        CFG_TURN_SCALE:  turn_scale_r  <= cfg_ch.data[TURN_W-1:0];
        CFG_GYRO_OFFSET: gyro_offset_r <= $signed(cfg_ch.data[GYRO_W-1:0]);
        default: ;
      endcase
    end
  end

  // Sample capture: encoder deltas wrap at 32 bits, heading biased positive
  logic signed [ENC_W-1:0]  dr;
  logic signed [ENC_W-1:0]  dl;
  logic signed [HU_W:0]     hv;
  logic signed [SUM_W-1:0]  sum_nxt;
  logic signed [VSP_W-1:0]  vsum_nxt;
  logic signed [VSP_W-1:0]  vdiff_nxt;

  assign dr        = in_ch.right_position - $signed(prev_right_r);
  assign dl        = in_ch.left_position - $signed(prev_left_r);
  assign sum_nxt   = SUM_W'(dr) + SUM_W'(dl);
  assign hv        = (HU_W+1)'(gyro_offset_r) - (HU_W+1)'(in_ch.gyro_angle)
                   + (HU_W+1)'(H_BIAS);
  assign vsum_nxt  = VSP_W'(in_ch.left_speed) + VSP_W'(in_ch.right_speed);
  assign vdiff_nxt = VSP_W'(in_ch.left_speed) - VSP_W'(in_ch.right_speed);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_right_r <= '0;
      prev_left_r  <= '0;
    end else if (in_fire) begin
      prev_right_r <= in_ch.right_position;
      prev_left_r  <= in_ch.left_position;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      sum_r   <= sum_nxt;
      hu_r    <= hv[HU_W-1:0];
      vsum_r  <= vsum_nxt;
      vdiff_r <= vdiff_nxt;
    end
  end

  // Shared multiplier operands
  logic signed [MUL_A_W-1:0] a_op;
  logic signed [MUL_B_W-1:0] b_op;
  logic signed [MUL_P_W-1:0] mul_full;

  always_comb begin
    case (ctrl.a_sel)
      A_U:     a_op = MUL_A_W'(hu_r);
      A_QUOT:  a_op = MUL_A_W'(prod_r[RECIP_SH+QUOT_W-1:RECIP_SH]);
      A_SUM:   a_op = MUL_A_W'(sum_r);
      A_M_LO:  a_op = MUL_A_W'(m_r[M_LO_W-1:0]);
      A_M_HI:  a_op = MUL_A_W'($signed(m_r[M_W-1:M_LO_W]));
      A_VSUM:  a_op = MUL_A_W'(vsum_r);
      A_VDIFF: a_op = MUL_A_W'(vdiff_r);
      default: a_op = '0;
    endcase
  end

  always_comb begin
    case (ctrl.b_sel)
      B_RECIP:  b_op = MUL_B_W'(RECIP);
      B_DEG360: b_op = MUL_B_W'(DEG_FULL);
      B_WHEEL:  b_op = MUL_B_W'(wheel_scale_r);
      B_COS:    b_op = MUL_B_W'(cos_r);
      B_SIN:    b_op = MUL_B_W'(sin_r);
      B_TURN:   b_op = MUL_B_W'(turn_scale_r);
      default:  b_op = '0;
    endcase
  end

  assign mul_full = a_op * b_op;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= mul_full;
    end
  end

  // Heading: remainder from the estimated quotient, one correction, fold to -179..180
  logic signed [HU_W:0]     rem;
  logic signed [HU_W:0]     rem_pos;
  logic signed [HEAD_W-1:0] heading_nxt;

  always_comb begin
    rem = $signed({1'b0, hu_r}) - $signed(prod_r[HU_W:0]);
    if (rem < 0) begin
      rem_pos = rem + (HU_W+1)'(DEG_FULL);
    end else begin
      rem_pos = rem;
    end
    if (rem_pos > DEG_HALF) begin
      heading_nxt = HEAD_W'(rem_pos - (HU_W+1)'(DEG_FULL));
    end else begin
      heading_nxt = HEAD_W'(rem_pos);
    end
  end

  // Sine and cosine of the heading from the quarter-wave table
  logic [HEAD_W-1:0]        habs;
  logic [ABS_W-1:0]         ang_a;
  logic [TAB_IDX_W-1:0]     sidx;
  logic [TAB_IDX_W-1:0]     cidx;
  logic                     cneg;
  logic signed [TRIG_W-1:0] sval;
  logic signed [TRIG_W-1:0] cval;
  logic signed [TRIG_W-1:0] sin_nxt;
  logic signed [TRIG_W-1:0] cos_nxt;

  always_comb begin
    habs  = heading_r[HEAD_W-1] ? HEAD_W'(-heading_r) : heading_r;
    ang_a = habs[ABS_W-1:0];
    if (ang_a <= ABS_W'(DEG_QTR)) begin
      sidx = TAB_IDX_W'(ang_a);
      cidx = TAB_IDX_W'(ABS_W'(DEG_QTR) - ang_a);
      cneg = 1'b0;
    end else begin
      sidx = TAB_IDX_W'(ABS_W'(DEG_HALF) - ang_a);
      cidx = TAB_IDX_W'(ang_a - ABS_W'(DEG_QTR));
      cneg = 1'b1;
    end
    sval    = TRIG_W'(SIN_TAB[sidx]);
    cval    = TRIG_W'(SIN_TAB[cidx]);
    sin_nxt = heading_r[HEAD_W-1] ? -sval : sval;
    cos_nxt = cneg ? -cval : cval;
  end

  // Working registers written from the product
  always_ff @(posedge clk) begin
    case (ctrl.wr_op)
      W_HEADING: heading_r <= heading_nxt;
      W_TRIG: begin
        m_r   <= prod_r[M_W-1:0];
        sin_r <= sin_nxt;
        cos_r <= cos_nxt;
      end
      W_LIN:   lin_r <= LIN_W'(prod_r >>> 1);
      default: ;
    endcase
  end

  // Position accumulators: low half floors by 2^shift, high half is pre-shifted
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_x_r <= '0;
      acc_y_r <= '0;
    end else begin
      case (ctrl.wr_op)
        W_X_LO:  acc_x_r <= acc_x_r + POS_W'(prod_r >>> TRIG_SHIFT);
        W_X_HI:  acc_x_r <= acc_x_r + (POS_W'(prod_r) <<< HI_SHIFT);
        W_Y_LO:  acc_y_r <= acc_y_r + POS_W'(prod_r >>> TRIG_SHIFT);
        W_Y_HI:  acc_y_r <= acc_y_r + (POS_W'(prod_r) <<< HI_SHIFT);
        default: ;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (result_wr) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_wr) begin
      out_x_r    <= acc_x_r;
      out_y_r    <= acc_y_r;
      out_head_r <= heading_r;
      out_lin_r  <= lin_r;
      out_ang_r  <= ANG_W'(prod_r);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pos_x        = out_x_r;
  assign out_ch.pos_y        = out_y_r;
  assign out_ch.heading      = out_head_r;
  assign out_ch.lin_velocity = out_lin_r;
  assign out_ch.ang_velocity = out_ang_r;

endmodule
`default_nettype wire

>>> rtl/gyro_wheel_odometry_unit.sv
// A result is written once its sample has run the microprogram on the single
//   shared 34x21 multiplier: quotient, remainder, fold, trig, lin, x low, x
//   high, y low, y high and result steps; no new sample is taken before then.
// A result not yet taken holds the last step until the result register frees.
// Reset (synchronous, rst_n low): registers return to their defaults, encoder
//   history and x/y accumulators clear, sequencer waits for a sample.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gyro_wheel_odometry_unit: planar odometry from wheel encoders and a gyro
// Microcoded sequencer driving a shared-multiplier datapath.
// ----------------------------------------------------------------------------
module gyro_wheel_odometry_unit import gwo_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  gwo_cfg_if.sink    cfg_ch,
  gwo_in_if.sink     in_ch,
  gwo_out_if.source  out_ch
);

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  // Control store and program counter
  gwo_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  // Arithmetic, state and result register
  gwo_datapath u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .stat   (stat),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for gyro_wheel_odometry_unit
// Drives encoder/gyro samples and register writes, and tracks heading, trig,
// x/y accumulation and wheel velocities in its own model. Every result is
// checked field by field, in order, under random idling on both channels.
// ----------------------------------------------------------------------------
module tb import gwo_pkg::*; ();

  localparam int          SETTLE_CYCLES = 16;     // result latency plus margin
  localparam int          HOLD_CYCLES   = 300;    // long receiver hold-off
  localparam int          TRIG_Q        = 15;     // sine/cosine fraction bits
  localparam longint unsigned PI_Q60_FIX = 64'h3243F6A8885A308D;
  localparam longint unsigned HALF_Q30   = 64'd1 << 29;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;  // not a register

  typedef struct {
    logic signed [ENC_W-1:0]   right_position;
    logic signed [ENC_W-1:0]   left_position;
    logic signed [GYRO_W-1:0]  gyro_angle;
    logic signed [SPEED_W-1:0] left_speed;
    logic signed [SPEED_W-1:0] right_speed;
  } sample_t;

  typedef struct {
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [HEAD_W-1:0] heading;
    logic signed [LIN_W-1:0]  lin_velocity;
    logic signed [ANG_W-1:0]  ang_velocity;
  } odom_t;

  logic clk;
  logic rst_n;

  gwo_in_if  in_bus ();
  gwo_out_if out_bus ();
  gwo_cfg_if cfg_bus ();

  gyro_wheel_odometry_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_bus),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  // Model state and register shadows
  logic [WHEEL_W-1:0]        wheel_scale_q;
  logic [TURN_W-1:0]         turn_scale_q;
  logic signed [GYRO_W-1:0]  gyro_offset_q;
  logic signed [ENC_W-1:0]   trk_prev_right;
  logic signed [ENC_W-1:0]   trk_prev_left;
  logic signed [POS_W-1:0]   trk_x;
  logic signed [POS_W-1:0]   trk_y;

  odom_t pending_odom[$];
  int    err_count;
  int    result_count;
  int    idle_pct;
  int    stall_pct;
  int    hold_seq;
  int    hold_seen;
  int    hold_left;

  // Clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Watchdog
  initial begin
    #4000000;
    $display("gyro_wheel_odometry_unit test failed");
    $finish;
  end

  // Fixed-point sine of whole degrees 0..90 via Taylor series in 2^-30 units
  function automatic longint sine_q15(input int deg);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    x    = longint'(deg) * (PI_Q60_FIX / 64'd180);
    x    = (x + HALF_Q30) >> 30;
    x2   = (x * x + HALF_Q30) >> 30;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 10; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    return (sum + (longint'(1) << (29 - TRIG_Q))) >>> (30 - TRIG_Q);
  endfunction

  // Advance the odometry model by one accepted sample
  function automatic odom_t advance_odometry(input sample_t s);
    odom_t                   r;
    logic signed [ENC_W-1:0] d_right;
    logic signed [ENC_W-1:0] d_left;
    logic signed [95:0]      wide;
    longint                  ws;
    longint                  ts;
    longint                  travel;
    longint                  sn;
    longint                  cs;
    longint                  lin_full;
    longint                  ang_full;
    int                      hdg;
    int                      mag;
    ws  = longint'(wheel_scale_q);
    ts  = longint'(turn_scale_q);
    hdg = (int'(gyro_offset_q) - int'(s.gyro_angle)) % 360;
    if (hdg < 0) begin
      hdg = hdg + 360;
    end
    if (hdg > 180) begin
      hdg = hdg - 360;
    end
    mag = (hdg < 0) ? -hdg : hdg;
    if (mag <= 90) begin
      sn = sine_q15(mag);
      cs = sine_q15(90 - mag);
    end else begin
      sn = sine_q15(180 - mag);
      cs = -sine_q15(mag - 90);
    end
    if (hdg < 0) begin
      sn = -sn;
    end
    // encoder deltas wrap at 32 bits
    d_right = s.right_position - trk_prev_right;
    d_left  = s.left_position - trk_prev_left;
    travel  = (longint'(d_right) + longint'(d_left)) * ws;
    wide    = 96'(travel) * 96'(cs);
    wide    = wide >>> (TRIG_Q + 1);
    trk_x   = trk_x + wide[POS_W-1:0];
    wide    = 96'(travel) * 96'(sn);
    wide    = wide >>> (TRIG_Q + 1);
    trk_y   = trk_y + wide[POS_W-1:0];
    trk_prev_right = s.right_position;
    trk_prev_left  = s.left_position;
    lin_full = ((longint'(s.left_speed) + longint'(s.right_speed)) * ws) >>> 1;
    ang_full = (longint'(s.left_speed) - longint'(s.right_speed)) * ts;
    r.pos_x        = trk_x;
    r.pos_y        = trk_y;
    r.heading      = hdg[HEAD_W-1:0];
    r.lin_velocity = lin_full[LIN_W-1:0];
    r.ang_velocity = ang_full[ANG_W-1:0];
    return r;
  endfunction

  function automatic sample_t make_sample(input int right, input int left, input int gyro,
                                          input int lspd, input int rspd);
    sample_t s;
    s.right_position = right;
    s.left_position  = left;
    s.gyro_angle     = gyro[GYRO_W-1:0];
    s.left_speed     = lspd[SPEED_W-1:0];
    s.right_speed    = rspd[SPEED_W-1:0];
    return s;
  endfunction

  // Mostly a random walk of the wheels and a gyro near calibration, some jumps
  function automatic sample_t random_sample();
    sample_t s;
    int      pick;
    pick = $urandom_range(99);
    if (pick < 8) begin
      s.right_position = $urandom;
      s.left_position  = $urandom;
    end else begin
      s.right_position = trk_prev_right + (int'($urandom_range(8000)) - 4000);
      s.left_position  = trk_prev_left + (int'($urandom_range(8000)) - 4000);
    end
    if ($urandom_range(99) < 70) begin
      s.gyro_angle = GYRO_W'(int'(gyro_offset_q) - (int'($urandom_range(800)) - 400));
    end else begin
      s.gyro_angle = GYRO_W'($urandom);
    end
    s.left_speed  = SPEED_W'($urandom);
    s.right_speed = SPEED_W'($urandom);
    if ($urandom_range(9) == 0) begin
      s.left_speed  = $urandom_range(1) ? 12'sh7FF : 12'sh800;
      s.right_speed = $urandom_range(1) ? 12'sh7FF : 12'sh800;
    end
    return s;
  endfunction

  function automatic void note_error(input string msg);
    err_count++;
    if (err_count <= 10) begin
      $display("%s", msg);
    end
  endfunction

  function automatic void check_field(input string fld, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      note_error($sformatf("result %0d %s: expected %h, got %h",
                           result_count, fld, want, got));
    end
  endfunction

  // Send one item; the model advances when it is accepted
  task automatic send_sample(input sample_t s);
    while ($urandom_range(99) < idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid          <= 1'b1;
    in_bus.right_position <= s.right_position;
    in_bus.left_position  <= s.left_position;
    in_bus.gyro_angle     <= s.gyro_angle;
    in_bus.left_speed     <= s.left_speed;
    in_bus.right_speed    <= s.right_speed;
    do @(posedge clk); while (!in_bus.ready);
    pending_odom.push_back(advance_odometry(s));
  endtask

  // Wait for all results, then let the pipeline go quiet
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (pending_odom.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    wait_idle();
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    case (idx)
      CFG_WHEEL_SCALE: wheel_scale_q = value[WHEEL_W-1:0];
      CFG_TURN_SCALE:  turn_scale_q  = value[TURN_W-1:0];
      CFG_GYRO_OFFSET: gyro_offset_q = value[GYRO_W-1:0];
      default: ;
    endcase
  endtask

  // Random filler in the high bits of the 16-bit registers checks truncation
  task automatic write_all_regs(input logic [WHEEL_W-1:0] wheel,
                                input logic [TURN_W-1:0] turn,
                                input logic signed [GYRO_W-1:0] offset);
    write_reg(CFG_WHEEL_SCALE, {4'($urandom), wheel});
    write_reg(CFG_TURN_SCALE, turn);
    write_reg(CFG_GYRO_OFFSET, {4'($urandom), offset});
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen     <= hold_seq;
      hold_left     <= HOLD_CYCLES;
      out_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Result check against the oldest expectation
  always @(posedge clk) begin : result_check
    odom_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_odom.size() == 0) begin
        note_error($sformatf("result %0d arrived with none expected", result_count));
      end else begin
        want = pending_odom.pop_front();
        check_field("pos_x", want.pos_x, out_bus.pos_x);
        check_field("pos_y", want.pos_y, out_bus.pos_y);
        check_field("heading", 64'(want.heading), 64'(out_bus.heading));
        check_field("lin_velocity", 64'(want.lin_velocity), 64'(out_bus.lin_velocity));
        check_field("ang_velocity", 64'(want.ang_velocity), 64'(out_bus.ang_velocity));
      end
      result_count++;
    end
  end

  // Default registers: encoder extremes, 32-bit wrap of deltas, speed extremes
  task automatic test_reset_defaults();
    send_sample(make_sample(0, 0, 0, 0, 0));
    send_sample(make_sample(32'sh80000000, 32'sh80000000, 0, 2047, 2047));
    send_sample(make_sample(32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, -2048, -2048));
    send_sample(make_sample(0, 32'sh7FFFFFFF, 0, 2047, -2048));
    send_sample(make_sample(-1, 32'sh80000000, 0, -2048, 2047));
  endtask

  // Half turn, multiples of ninety and gyro extremes, with the robot moving
  task automatic test_heading_wrap();
    int gyro_list[13] = '{180, -180, 90, -90, 270, -270, 360, 0, 179, -179, 181,
                          32767, -32768};
    foreach (gyro_list[i]) begin
      send_sample(make_sample(trk_prev_right + 1000, trk_prev_left + 600, gyro_list[i],
                              $urandom_range(4095), $urandom_range(4095)));
    end
  endtask

  // Register extremes; a write to an index past the list must change nothing
  task automatic test_register_extremes();
    write_all_regs(16'd0, 20'd0, 16'sh8000);
    send_sample(make_sample(trk_prev_right + 5, trk_prev_left - 9, 32767, 2047, -2048));
    repeat (18) send_sample(random_sample());
    write_all_regs(16'hFFFF, 20'hFFFFF, 16'sh7FFF);
    send_sample(make_sample(trk_prev_right + 2047, trk_prev_left + 2047, -32768,
                            -2048, 2047));
    send_sample(make_sample(trk_prev_right - 70000, trk_prev_left - 90000, 32767,
                            2047, 2047));
    repeat (18) send_sample(random_sample());
    write_reg(CFG_SPARE_IDX, 20'($urandom));
    repeat (10) send_sample(random_sample());
    write_all_regs(16'd1, 20'd1, -16'sd1);
    repeat (15) send_sample(random_sample());
  endtask

  // Random traffic under each idling phase, fresh register values per phase
  task automatic test_random_traffic();
    int idle_list[4]  = '{0, 60, 0, 22};
    int stall_list[4] = '{0, 0, 60, 22};
    foreach (idle_list[p]) begin
      write_all_regs(WHEEL_W'($urandom), TURN_W'($urandom), GYRO_W'($urandom));
      idle_pct  = idle_list[p];
      stall_pct = stall_list[p];
      repeat (250) send_sample(random_sample());
    end
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  // Receiver holds off while items keep coming; then the sender drains and resumes
  task automatic test_backpressure();
    write_all_regs(16'd8785, 20'd73206, 16'sd0);
    idle_pct  = 0;
    stall_pct = 10;
    hold_seq  = hold_seq + 1;
    repeat (30) send_sample(random_sample());
    wait_idle();
    repeat (15) send_sample(random_sample());
    stall_pct = 0;
  endtask

  // Main sequence
  initial begin
    rst_n          = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.right_position = '0;
    in_bus.left_position  = '0;
    in_bus.gyro_angle     = '0;
    in_bus.left_speed     = '0;
    in_bus.right_speed    = '0;
    out_bus.ready  = 1'b0;
    cfg_bus.valid  = 1'b0;
    cfg_bus.index  = '0;
    cfg_bus.data   = '0;
    wheel_scale_q  = 16'd8785;
    turn_scale_q   = 20'd73206;
    gyro_offset_q  = '0;
    trk_prev_right = '0;
    trk_prev_left  = '0;
    trk_x          = '0;
    trk_y          = '0;
    err_count      = 0;
    result_count   = 0;
    idle_pct       = 0;
    stall_pct      = 0;
    hold_seq       = 0;
    hold_seen      = 0;
    hold_left      = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_heading_wrap();
    test_register_extremes();
    test_random_traffic();
    test_backpressure();

    wait_idle();
    if (err_count == 0 && pending_odom.size() == 0) begin
      $display("gyro_wheel_odometry_unit test passed");
    end else begin
      $display("gyro_wheel_odometry_unit test failed");
    end
    $finish;
  end

endmodule
